// ===== rtl/core/rgbhsi_pkg.sv =====
`default_nettype none
package rgbhsi_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned SumW = 10;
  localparam int unsigned ChanW = 8;

  // Hue sector of the largest channel, red tested first.
  typedef enum logic [1:0] {
    SectorRed   = 2'd0,
    SectorGreen = 2'd1,
    SectorBlue  = 2'd2,
    SectorGrey  = 2'd3
  } sector_e;

  // Classified pixel passed from the front part to the back part.
  typedef struct packed {
    logic [SumW-1:0]  sum;
    logic [SumW-1:0]  sat_num;
    logic [ChanW-1:0] span;
    logic [SumW:0]    hue_num;
    sector_e          sector;
  } class_t;

  // Shared restoring division step: one quotient bit.
  typedef struct packed {
    logic [SumW+1:0] rem;
    logic            bit_q;
  } div_step_t;

  function automatic div_step_t div_step(input logic [SumW+1:0] rem_in,
                                         input logic [SumW+1:0] den);
    div_step_t res;
    logic [SumW+2:0] shifted;
    shifted = {rem_in, 1'b0};
    if (shifted >= {1'b0, den}) begin
      res.rem = (SumW+2)'(shifted - {1'b0, den});
      res.bit_q = 1'b1;
    end else begin
      res.rem = shifted[SumW+1:0];
      res.bit_q = 1'b0;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rgb_to_hsi_converter.sv =====
// RGB to HSI pixel converter.
// Input side is a queue: drive rgb_word_i and raise push; the item is
// taken on a clock edge where push is high and full is low.
// Output side is a queue: while empty is low the oldest result sits on
// hue_fraction_o, saturation_fraction_o and intensity_fraction_o; it is
// taken on an edge where pop is high.
// A combinational front part finds min, max, sum and the hue sector and
// writes a short queue; the back part runs FRAC_BITS+1 pipelined
// long-division stages, one quotient bit of hue and saturation per stage,
// while intensity comes from a reciprocal multiplication in the first stage.
// Throughput is one item per cycle while pop keeps up.
// If pop stays low the division pipeline fills, then the queue, then
// full rises; no item is lost or repeated.
// Reset empties the queue and the pipeline; full and empty read as
// not full and empty right after reset.
`default_nettype none
module rgb_to_hsi_converter #(
  parameter int unsigned FRAC_BITS = rgbhsi_pkg::FracBitsDefault,
  parameter int unsigned QueueDepth = rgbhsi_pkg::QueueDepthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [23:0]          rgb_word_i,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [FRAC_BITS-1:0]      hue_fraction_o,
  output logic [FRAC_BITS:0]        saturation_fraction_o,
  output logic [FRAC_BITS:0]        intensity_fraction_o
);
  import rgbhsi_pkg::*;

  class_t cls_in, cls_out;
  logic q_empty, back_ready, out_valid;

  rgbhsi_front u_front (
    .rgb_word_i (rgb_word_i),
    .cls_o      (cls_in)
  );

  rgbhsi_fifo #(
    .Width ($bits(class_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_in),
    .full_o  (full),
    .pop_i   (back_ready),
    .empty_o (q_empty),
    .data_o  (cls_out)
  );

  rgbhsi_back #(
    .FracBits (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!q_empty),
    .cls_i       (cls_out),
    .in_ready_o  (back_ready),
    .out_valid_o (out_valid),
    .out_ready_i (pop),
    .hue_o       (hue_fraction_o),
    .sat_o       (saturation_fraction_o),
    .inten_o     (intensity_fraction_o)
  );

  assign empty = !out_valid;

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> saturation_fraction_o <= (FRAC_BITS+1)'(1 << FRAC_BITS))
    else $error("saturation above one");
  a_int_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> intensity_fraction_o <= (FRAC_BITS+1)'(1 << FRAC_BITS))
    else $error("intensity above one");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(hue_fraction_o)))
    else $error("result changed while stalled");

endmodule
`default_nettype wire

// ===== rtl/core/rgbhsi_front.sv =====
`default_nettype none
module rgbhsi_front (
  input  wire logic [23:0]            rgb_word_i,
  output rgbhsi_pkg::class_t          cls_o
);
  import rgbhsi_pkg::*;

  logic [ChanW-1:0] r, g, b, hi, lo;
  logic [SumW:0] num;
  logic [SumW:0] six_span;

  always_comb begin
    r = rgb_word_i[23:16];
    g = rgb_word_i[15:8];
    b = rgb_word_i[7:0];
    lo = (r < g) ? ((b < r) ? b : r) : ((b < g) ? b : g);
    hi = (r > g) ? ((b > r) ? b : r) : ((b > g) ? b : g);
    cls_o.sum = SumW'(r) + SumW'(g) + SumW'(b);
    cls_o.sat_num = cls_o.sum - SumW'(3 * lo);
    cls_o.span = hi - lo;
    six_span = (SumW+1)'(cls_o.span) * (SumW+1)'(6);
    // Numerator over 6*span, offset by 2*span per sector and wrapped.
    if (cls_o.span == '0) begin
      cls_o.sector = SectorGrey;
      num = '0;
    end else if (hi == r) begin
      cls_o.sector = SectorRed;
      num = (SumW+1)'(g) - (SumW+1)'(b);
      if (g < b) num = num + six_span;
    end else if (hi == g) begin
      cls_o.sector = SectorGreen;
      num = (SumW+1)'(b) - (SumW+1)'(r) + ((SumW+1)'(cls_o.span) << 1);
    end else begin
      cls_o.sector = SectorBlue;
      num = (SumW+1)'(r) - (SumW+1)'(g) + ((SumW+1)'(cls_o.span) << 2);
    end
    cls_o.hue_num = num;
  end
endmodule
`default_nettype wire

// ===== rtl/core/rgbhsi_fifo.sv =====
`default_nettype none
module rgbhsi_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [Width-1:0]      data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0] cnt_q;
  logic do_push, do_pop;

  assign full_o = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/rgbhsi_back.sv =====
`default_nettype none
module rgbhsi_back #(
  parameter int unsigned FracBits = rgbhsi_pkg::FracBitsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  rgbhsi_pkg::class_t        cls_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [FracBits-1:0]       hue_o,
  output logic [FracBits:0]         sat_o,
  output logic [FracBits:0]         inten_o
);
  import rgbhsi_pkg::*;

  // Pipeline of FracBits+1 long-division stages; each stage yields one
  // quotient bit of hue and saturation (integer bit first). Intensity is
  // a reciprocal multiplication in the first stage and rides along.
  localparam int unsigned Stages = FracBits + 1;
  localparam int unsigned RemW = SumW + 2;
  localparam int unsigned RecipShift = 20;
  localparam int unsigned MulW = FracBits + 12;
  localparam longint unsigned IntenDen = 765;
  // With a 20-bit shift the rounding excess stays below 1/765 for any sum
  // up to 765, so the truncated product equals the exact floor.
  localparam longint unsigned InvMul =
      ((64'd1 << (FracBits + RecipShift)) + IntenDen - 64'd1) / IntenDen;
  localparam logic [MulW-1:0] InvMulQ = MulW'(InvMul);

  typedef struct packed {
    logic [RemW-1:0] rem_h, rem_s;
    logic [RemW-1:0] den_h, den_s;
    logic [FracBits:0] q_h, q_s, q_i;
    logic zero_h, zero_s;
  } lane_t;

  lane_t st_q [Stages];
  lane_t st_d [Stages];
  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] adv;
  logic [SumW+MulW-1:0] inten_prod;
  lane_t head;

  // The whole numerator against the divisor gives the integer bit.
  function automatic div_step_t first_step(input logic [RemW-1:0] num,
                                           input logic [RemW-1:0] den);
    div_step_t res;
    if (num >= den) begin
      res.rem = num - den;
      res.bit_q = 1'b1;
    end else begin
      res.rem = num;
      res.bit_q = 1'b0;
    end
    return res;
  endfunction

  always_comb begin
    div_step_t sh, ss;
    inten_prod = {{MulW{1'b0}}, cls_i.sum} * {{SumW{1'b0}}, InvMulQ};
    head.den_h = RemW'(cls_i.span) * RemW'(6);
    head.den_s = RemW'(cls_i.sum);
    sh = first_step(RemW'(cls_i.hue_num), head.den_h);
    ss = first_step(RemW'(cls_i.sat_num), head.den_s);
    head.rem_h = sh.rem;
    head.rem_s = ss.rem;
    head.q_h = (FracBits+1)'(sh.bit_q);
    head.q_s = (FracBits+1)'(ss.bit_q);
    head.q_i = inten_prod[FracBits+RecipShift -: FracBits+1];
    head.zero_h = (cls_i.sector == SectorGrey);
    head.zero_s = (cls_i.sum == '0);
  end

  always_comb begin
    div_step_t sh, ss;
    st_d[0] = head;
    for (int k = 1; k < Stages; k++) begin
      sh = div_step(st_q[k-1].rem_h, st_q[k-1].den_h);
      ss = div_step(st_q[k-1].rem_s, st_q[k-1].den_s);
      st_d[k] = st_q[k-1];
      st_d[k].rem_h = sh.rem;
      st_d[k].rem_s = ss.rem;
      st_d[k].q_h = {st_q[k-1].q_h[FracBits-1:0], sh.bit_q};
      st_d[k].q_s = {st_q[k-1].q_s[FracBits-1:0], ss.bit_q};
    end
  end

  // Stall-aware pipeline: a stage advances when the next one is free.
  always_comb begin
    adv[Stages-1] = !vld_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0];
  assign out_valid_o = vld_q[Stages-1];
  assign hue_o = st_q[Stages-1].zero_h ? '0 : st_q[Stages-1].q_h[FracBits-1:0];
  assign sat_o = st_q[Stages-1].zero_s ? '0 : st_q[Stages-1].q_s;
  assign inten_o = st_q[Stages-1].q_i;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Stages; k++) begin
      if (adv[k]) st_q[k] <= st_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end
endmodule
`default_nettype wire

// ===== sim/hsi_checker.sv =====
module hsi_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [23:0] rgb_word_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [15:0] hue_fraction_o,
  input  logic [16:0] saturation_fraction_o,
  input  logic [16:0] intensity_fraction_o,
  output int          fail_count,
  output int          pending_count
);
  import rgbhsi_pkg::*;

  typedef struct packed {
    logic [15:0] hue;
    logic [16:0] sat;
    logic [16:0] inten;
  } hsi_t;

  hsi_t hsi_expected_q[$];

  function automatic hsi_t rgb_to_hsi(logic [23:0] word);
    hsi_t res;
    longint r, g, b, lo, hi, sum, span, num, k;
    sector_e sector;
    r = word[23:16];
    g = word[15:8];
    b = word[7:0];
    sum = r + g + b;
    lo = (r < g) ? ((b < r) ? b : r) : ((b < g) ? b : g);
    hi = (r > g) ? ((b > r) ? b : r) : ((b > g) ? b : g);
    span = hi - lo;
    res.inten = 17'((sum << 16) / 765);
    res.sat = (sum != 0) ? 17'(((sum - 3 * lo) << 16) / sum) : '0;
    if (span == 0) sector = SectorGrey;
    else if (hi == r) sector = SectorRed;
    else if (hi == g) sector = SectorGreen;
    else sector = SectorBlue;
    k = 0;
    num = 0;
    case (sector)
      SectorRed: begin k = 0; num = g - b; end
      SectorGreen: begin k = 2; num = b - r; end
      SectorBlue: begin k = 4; num = r - g; end
      default: ;
    endcase
    if (sector == SectorGrey) begin
      res.hue = '0;
    end else begin
      num += k * span;
      if (num < 0) num += 6 * span;
      res.hue = 16'((num << 16) / (6 * span));
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hsi_t want;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (push && !full) hsi_expected_q.push_back(rgb_to_hsi(rgb_word_i));
      if (pop && !empty) begin
        if (hsi_expected_q.size() == 0) begin
          $error("result with no item outstanding");
          errs++;
        end else begin
          want = hsi_expected_q.pop_front();
          if (want.hue !== hue_fraction_o) begin
            $error("hue_fraction: expected %0d actual %0d", want.hue, hue_fraction_o);
            errs++;
          end
          if (want.sat !== saturation_fraction_o) begin
            $error("saturation_fraction: expected %0d actual %0d", want.sat,
                   saturation_fraction_o);
            errs++;
          end
          if (want.inten !== intensity_fraction_o) begin
            $error("intensity_fraction: expected %0d actual %0d", want.inten,
                   intensity_fraction_o);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_count <= hsi_expected_q.size();
    end
  end
endmodule

// ===== sim/tb.sv =====
module tb;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [23:0] rgb_word_i = '0;
  logic full, empty;
  logic [15:0] hue_fraction_o;
  logic [16:0] saturation_fraction_o, intensity_fraction_o;
  int fail_count, pending_count;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  bit hold_pop = 1'b0;
  int idle_cycles = 0;
  int sent_items = 0;
  logic [23:0] pixel_list[$];

  always #10 clk_i = ~clk_i;

  rgb_to_hsi_converter dut (.*);

  hsi_checker u_checker (.*);

  // The receiver stalls at random, or for a counted stretch when asked.
  always @(posedge clk_i) begin
    if (!rst_ni || hold_pop) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // Watchdog on cycles without any accepted item or result.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [23:0] random_pixel();
    logic [7:0] r, g, b;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    case ($urandom_range(5))
      0: g = r;
      1: b = g;
      2: begin g = r; b = r; end
      3: b = r;
      default: ;
    endcase
    return {r, g, b};
  endfunction

  task automatic send_pixel(logic [23:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    rgb_word_i <= px;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_items++;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  initial begin
    pixel_list = '{24'h000000, 24'hffffff, 24'h808080, 24'hff0000, 24'h00ff00,
                   24'h0000ff, 24'hffff00, 24'h00ffff, 24'hff00ff, 24'hff00ff,
                   24'hff0001, 24'h0000fe, 24'h01ff00, 24'h010203, 24'h030201,
                   24'hfe0102, 24'h00ff01, 24'h5555aa, 24'haa5555, 24'h55aa55,
                   24'h000001, 24'haaaaaa};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (pixel_list[i]) send_pixel(pixel_list[i]);
    drain_results();

    // Hold the receiver off for a counted stretch while items keep coming,
    // so the pipeline and the queue fill and full rises.
    fork
      begin
        hold_pop <= 1'b1;
        repeat (80) @(posedge clk_i);
        hold_pop <= 1'b0;
      end
      repeat (40) send_pixel(random_pixel());
    join
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 12 : 59) : 0;
      pop_stall_pct = (phase == 2) ? 59 : ((phase == 3) ? 12 : 0);
      for (int n = 0; n < 170; n++) begin
        if ($urandom_range(3) == 0) send_pixel(24'($urandom));
        else send_pixel(random_pixel());
      end
      drain_results();
    end
    repeat (30) @(posedge clk_i);

    $display("Converted %0d pixels: primaries, greys, ties, wraps and random colors,",
             sent_items);
    $display("under free flow, sender gaps, receiver stalls and a full backlog.");
    if (fail_count == 0 && pending_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== rgb_to_hsi_converter.f =====
rtl/core/rgbhsi_pkg.sv
rtl/core/rgbhsi_front.sv
rtl/core/rgbhsi_fifo.sv
rtl/core/rgbhsi_back.sv
rtl/core/rgb_to_hsi_converter.sv
sim/hsi_checker.sv
sim/tb.sv
